// ===== hw/rtl/ugh_pkg.sv =====
// ----------------------------------------------------------------------------
// ugh_pkg: shared constants of the uniform grid histogram
// Register indexes, mode codes, bin limits and defaults.
// ----------------------------------------------------------------------------
package ugh_pkg;

  localparam int DEF_MAX_CELLS_X = 64;
  localparam int DEF_MAX_CELLS_Y = 64;

  localparam int BIN_W = 48;

  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_FIRST_X = 3'd1;
  localparam logic [2:0] REG_STEP_X  = 3'd2;
  localparam logic [2:0] REG_FIRST_Y = 3'd3;
  localparam logic [2:0] REG_STEP_Y  = 3'd4;
  localparam logic [2:0] REG_CELLS_X = 3'd5;
  localparam logic [2:0] REG_CELLS_Y = 3'd6;

  localparam logic [1:0] MODE_1D_COUNT    = 2'd0;
  localparam logic [1:0] MODE_1D_WEIGHTED = 2'd1;
  localparam logic [1:0] MODE_2D_COUNT    = 2'd2;

  localparam logic signed [BIN_W-1:0] BIN_MAX = {1'b0, {(BIN_W-1){1'b1}}};
  localparam logic signed [BIN_W-1:0] BIN_MIN = {1'b1, {(BIN_W-1){1'b0}}};
  localparam logic signed [BIN_W-1:0] ONE_Q16 = 48'sd65536;

endpackage

// ===== hw/rtl/ugh_div.sv =====
// ----------------------------------------------------------------------------
// ugh_div: floor cell locator for one axis
// Radix-2 restoring division of (sample - first) by step, one quotient bit per
// cycle, floor rounding, range check against the cell count.
// ----------------------------------------------------------------------------
module ugh_div #(
  parameter int CELLS_W = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] sample,
  input  logic signed [31:0] first,
  input  logic [30:0]        step,
  input  logic [CELLS_W-1:0] cells,
  output logic               done,
  output logic               ok,
  output logic [CELLS_W-1:0] cell_idx
);

  localparam int DW = 33;
  localparam int CW = $clog2(DW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] num_r, num_nxt;   // magnitude, shifted out msb first
  logic [DW-1:0] quo_r, quo_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [30:0]   step_r;
  logic [CELLS_W-1:0] cells_r;

  logic signed [DW-1:0] diff;
  logic [32:0]          trial;
  logic signed [DW+1:0] q;

  assign diff = DW'(sample) - DW'(first);
  assign trial = {rem_r, num_r[DW-1]} - {2'b0, step_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      neg_nxt  = diff[DW-1];
      num_nxt  = diff[DW-1] ? DW'(-diff) : DW'(diff);
      quo_nxt  = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], num_r[DW-1]};
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      num_nxt = {num_r[DW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    if (start) begin
      step_r  <= step;
      cells_r <= cells;
    end
  end

  // floor: negative with remainder rounds one further down
  always_comb begin
    if (neg_r) q = -$signed({2'b0, quo_r}) - $signed({{(DW+1){1'b0}}, (rem_r != '0)});
    else       q = $signed({2'b0, quo_r});
  end

  assign done     = done_r;
  assign ok       = (step_r != '0) && !q[DW+1] &&
                    (q < $signed({{(DW+2-CELLS_W){1'b0}}, cells_r}));
  assign cell_idx = q[CELLS_W-1:0];

endmodule

// ===== hw/rtl/uniform_grid_histogram_unit.sv =====
// ----------------------------------------------------------------------------
// uniform_grid_histogram_unit: weighted / 2D histogram on a uniform grid
// Top level: config registers, locators, bin memory read-modify-write.
// ----------------------------------------------------------------------------
// One item at a time; the bit-serial locator sets the rate. A valid read item
// goes from accept through memory read, write back and result to the next
// accept, skipping the write back when the index is invalid. An add item runs a
// 33-step floor division of (sample - first) by step per axis, in 2D mode
// with the y division following the x one; unless dropped, the bin memory is
// then read, updated with saturation and written. After reset a clearing pass
// writes zero to every bin, one bin a cycle; no item is taken then,
// configuration writes are. The result beat waits in an output register while
// the next item is taken; only the result stage of that next item holds until
// the register is free.
// ----------------------------------------------------------------------------
module uniform_grid_histogram_unit #(
  parameter int MAX_CELLS_X = ugh_pkg::DEF_MAX_CELLS_X,
  parameter int MAX_CELLS_Y = ugh_pkg::DEF_MAX_CELLS_Y
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: sample_x[31:0], sample_y[63:32], weight[95:64],
  //        read_x[101:96], read_y[107:102], zero pad [111:108]
  input  logic [111:0] in_tdata,
  input  logic         in_tuser,   // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: in_range[0], cell_x[6:1], cell_y[12:7], bin_value[60:13],
  //        saturated[61], zero pad [63:62]
  output logic [63:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int BW    = ugh_pkg::BIN_W;
  localparam int XW    = (MAX_CELLS_X > 1) ? $clog2(MAX_CELLS_X) : 1;
  localparam int DEPTH = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CXW   = $clog2(MAX_CELLS_X + 1) > 7 ? $clog2(MAX_CELLS_X + 1) : 7;
  localparam int CYW   = $clog2(MAX_CELLS_Y + 1) > 7 ? $clog2(MAX_CELLS_Y + 1) : 7;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIVX  = 3'd2;
  localparam logic [2:0] S_DIVY  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // config registers
  logic [1:0]         mode_r;
  logic signed [31:0] first_x_r, first_y_r;
  logic [30:0]        step_x_r, step_y_r;
  logic [6:0]         cells_x_r, cells_y_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ugh_pkg::MODE_1D_COUNT;
      first_x_r <= '0;
      step_x_r  <= 31'd65536;
      first_y_r <= '0;
      step_y_r  <= 31'd65536;
      cells_x_r <= 7'd64;
      cells_y_r <= 7'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ugh_pkg::REG_MODE:    mode_r    <= cfg_data[1:0];
        ugh_pkg::REG_FIRST_X: first_x_r <= cfg_data;
        ugh_pkg::REG_STEP_X:  step_x_r  <= cfg_data[30:0];
        ugh_pkg::REG_FIRST_Y: first_y_r <= cfg_data;
        ugh_pkg::REG_STEP_Y:  step_y_r  <= cfg_data[30:0];
        ugh_pkg::REG_CELLS_X: cells_x_r <= cfg_data[6:0];
        ugh_pkg::REG_CELLS_Y: cells_y_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic two_d, weighted;
  assign two_d    = (mode_r == ugh_pkg::MODE_2D_COUNT);
  assign weighted = (mode_r == ugh_pkg::MODE_1D_WEIGHTED);

  // clamped cell counts
  logic [CXW-1:0] cx_n;
  logic [CYW-1:0] cy_n;
  always_comb begin
    if (CXW'(cells_x_r) > CXW'(MAX_CELLS_X)) cx_n = CXW'(MAX_CELLS_X);
    else                                     cx_n = CXW'(cells_x_r);
    if (!two_d)                                   cy_n = CYW'(1);
    else if (CYW'(cells_y_r) > CYW'(MAX_CELLS_Y)) cy_n = CYW'(MAX_CELLS_Y);
    else                                          cy_n = CYW'(cells_y_r);
  end

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] clr_r;
  logic          cmd_r;
  logic signed [31:0] sx_r, sy_r, wt_r;
  logic [5:0]    rx_r, ry_r;
  logic          ok_r;
  logic [AW-1:0] addr_r;
  logic signed [BW-1:0] val_r;
  logic          sat_r;
  logic          out_valid_r;
  logic [63:0]   out_data_r;
  // set once the y division is running
  logic          ypass_r;

  // shared bit-serial locator; x starts straight from the input beat
  logic            dx_start, div_done, div_ok;
  logic signed [31:0] d_sample, d_first;
  logic [30:0]     d_step;
  logic [CXW+CYW-1:0] d_cells;
  logic [CXW+CYW-1:0] d_cell;

  assign d_sample = (state_r == S_DIVX) ? sy_r : in_tdata[31:0];
  assign d_first  = (state_r == S_DIVX) ? first_y_r : first_x_r;
  assign d_step   = (state_r == S_DIVX) ? step_y_r : step_x_r;
  assign d_cells  = (state_r == S_DIVX) ? (CXW+CYW)'(cy_n) : (CXW+CYW)'(cx_n);

  ugh_div #(.CELLS_W(CXW+CYW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dx_start),
    .sample(d_sample), .first(d_first), .step(d_step), .cells(d_cells),
    .done(div_done), .ok(div_ok), .cell_idx(d_cell)
  );

  // bin memory
  logic signed [BW-1:0] mem [DEPTH];
  logic signed [BW-1:0] rd_data_r;
  logic          we;
  logic [AW-1:0] wa;
  logic signed [BW-1:0] wd;

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data_r <= mem[addr_r];
  end

  logic [XW-1:0] cellx_r;

  assign in_tready = (state_r == S_IDLE);

  // result register takes a beat when empty or draining this cycle
  logic out_load;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // add with saturation
  logic signed [BW:0] sum;
  logic signed [BW-1:0] inc;
  assign inc = weighted ? BW'(wt_r) : ugh_pkg::ONE_Q16;
  assign sum = {rd_data_r[BW-1], rd_data_r} + {inc[BW-1], inc};

  always_comb begin
    state_nxt = state_r;
    dx_start  = 1'b0;
    we        = 1'b0;
    wa        = addr_r;
    wd        = '0;
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          if (in_tuser) state_nxt = S_RD;
          else begin
            dx_start  = 1'b1;
            state_nxt = S_DIVX;
          end
        end
      end
      S_DIVX: begin
        // first pass is x; when done either start y, go to memory, or drop to the result
        if (div_done) begin
          if (!div_ok) state_nxt = S_OUT;
          else if (two_d && !ypass_r) begin
            dx_start  = 1'b1;
            state_nxt = S_DIVY;
          end else state_nxt = S_RD;
        end
      end
      S_DIVY: state_nxt = S_DIVX;
      S_RD: state_nxt = ok_r ? S_WR : S_OUT;
      S_WR: begin
        we = 1'b1;
        if (cmd_r) wd = '0;
        else if (sum[BW] != sum[BW-1]) wd = sum[BW] ? ugh_pkg::BIN_MIN : ugh_pkg::BIN_MAX;
        else wd = sum[BW-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      ypass_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (state_r == S_DIVY) ypass_r <= 1'b1;
      else if (state_r == S_IDLE) ypass_r <= 1'b0;
    end

    if (state_r == S_IDLE && in_tvalid && in_tready) begin
      cmd_r <= in_tuser;
      sx_r  <= in_tdata[31:0];
      sy_r  <= in_tdata[63:32];
      wt_r  <= in_tdata[95:64];
      rx_r  <= in_tdata[101:96];
      ry_r  <= two_d ? in_tdata[107:102] : 6'd0;
      sat_r <= 1'b0;
      val_r <= '0;
      ok_r  <= in_tuser ? (CXW'(in_tdata[101:96]) < cx_n &&
                           CYW'(two_d ? in_tdata[107:102] : 6'd0) < cy_n) : 1'b0;
      addr_r <= AW'(two_d ? in_tdata[107:102] : 6'd0) * AW'(MAX_CELLS_X)
                + AW'(in_tdata[101:96]);
    end
    if (state_r == S_DIVX && div_done) begin
      if (!div_ok) begin
        ok_r <= 1'b0;
        rx_r <= '0;
        ry_r <= '0;
      end else if (!ypass_r) begin
        rx_r    <= 6'(d_cell);
        cellx_r <= XW'(d_cell);
        ok_r    <= 1'b1;
        if (!two_d) addr_r <= AW'(d_cell);
      end else begin
        ry_r   <= 6'(d_cell);
        addr_r <= AW'(d_cell) * AW'(MAX_CELLS_X) + AW'(cellx_r);
      end
    end
    if (state_r == S_WR) begin
      if (cmd_r) val_r <= rd_data_r;
      else begin
        val_r <= wd;
        sat_r <= (sum[BW] != sum[BW-1]);
      end
    end
    if (out_load)
      out_data_r <= {2'b0, sat_r, val_r, ry_r, rx_r, ok_r};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for uniform_grid_histogram_unit
// Drives add and read beats through the stream ports, keeps a shadow of the
// bin store and registers, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ugh_pkg::*;

  localparam int MAXX = DEF_MAX_CELLS_X;
  localparam int MAXY = DEF_MAX_CELLS_Y;
  localparam int LIMIT = 1500000;
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic        sat;
    logic [47:0] value;
    logic [5:0]  cy;
    logic [5:0]  cx;
    logic        ok;
  } bin_result_t;

  typedef struct {
    logic        cmd;
    logic [31:0] sx, sy, wt;
    logic [5:0]  rx, ry;
    bit          has_exp;
    bin_result_t exp_res;
  } stim_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tuser;
  logic [111:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [63:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  uniform_grid_histogram_unit u_top (.*);

  // shadow state
  logic signed [47:0] shadow_bins [MAXX*MAXY];
  logic [1:0] sh_mode;
  logic signed [31:0] sh_first_x, sh_first_y;
  logic [30:0] sh_step_x, sh_step_y;
  logic [6:0] sh_cells_x, sh_cells_y;

  bin_result_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // floor cell index on one axis; -1 when dropped
  function automatic int grid_cell(logic signed [31:0] s, logic signed [31:0] f,
                                   logic [30:0] st, int n);
    longint d, q, sl;
    if (st == 0) return -1;
    sl = longint'(st);
    d = longint'(s) - longint'(f);
    q = d / sl;
    if (d < 0 && q * sl != d) q = q - 1;
    if (q < 0 || q >= n) return -1;
    return int'(q);
  endfunction

  function automatic bin_result_t predict_bin(logic cmd, logic [31:0] sx, logic [31:0] sy,
                                              logic [31:0] wt, logic [5:0] rx,
                                              logic [5:0] ry);
    bin_result_t r;
    bit two_d;
    int nx, ny, cx, cy;
    longint v;
    two_d = (sh_mode == MODE_2D_COUNT);
    nx = (sh_cells_x > MAXX) ? MAXX : int'(sh_cells_x);
    ny = two_d ? ((sh_cells_y > MAXY) ? MAXY : int'(sh_cells_y)) : 1;
    r = '0;
    if (cmd == CMD_READ) begin
      cx = int'(rx);
      cy = two_d ? int'(ry) : 0;
      r.cx = 6'(cx);
      r.cy = 6'(cy);
      r.ok = (cx < nx) && (cy < ny);
      if (r.ok) begin
        r.value = shadow_bins[cy*MAXX+cx];
        shadow_bins[cy*MAXX+cx] = '0;
      end
    end else begin
      cx = grid_cell(sx, sh_first_x, sh_step_x, nx);
      cy = 0;
      if (cx >= 0 && two_d) cy = grid_cell(sy, sh_first_y, sh_step_y, ny);
      if (cx >= 0 && cy >= 0) begin
        v = longint'(shadow_bins[cy*MAXX+cx]) +
            ((sh_mode == MODE_1D_WEIGHTED) ? longint'($signed(wt)) : 64'sd65536);
        if (v > longint'(BIN_MAX)) begin v = longint'(BIN_MAX); r.sat = 1; end
        if (v < longint'(BIN_MIN)) begin v = longint'(BIN_MIN); r.sat = 1; end
        shadow_bins[cy*MAXX+cx] = v[47:0];
        r.ok = 1;
        r.cx = 6'(cx);
        r.cy = 6'(cy);
        r.value = v[47:0];
      end
    end
    return r;
  endfunction

  // result side: random stall and compare
  always @(posedge clk) begin
    bin_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[61:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.ok !== want.ok || got.cx !== want.cx || got.cy !== want.cy ||
            got.value !== want.value || got.sat !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp ok=%b x=%0d y=%0d v=%h s=%b, got ok=%b x=%0d y=%0d v=%h s=%b",
                     want.ok, want.cx, want.cy, want.value, want.sat,
                     got.ok, got.cx, got.cy, got.value, got.sat);
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_MODE:    sh_mode = val[1:0];
      REG_FIRST_X: sh_first_x = val;
      REG_STEP_X:  sh_step_x = val[30:0];
      REG_FIRST_Y: sh_first_y = val;
      REG_STEP_Y:  sh_step_y = val[30:0];
      REG_CELLS_X: sh_cells_x = val[6:0];
      REG_CELLS_Y: sh_cells_y = val[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // drain, then cover the add latency before touching registers
  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // valid stays up after a beat; callers drop it when the burst ends
  task automatic push_beat(stim_row_t row);
    bin_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= row.cmd;
    in_tdata <= {4'b0, row.ry, row.rx, row.wt, row.sy, row.sx};
    do @(posedge clk); while (!in_tready);
    r = predict_bin(row.cmd, row.sx, row.sy, row.wt, row.rx, row.ry);
    if (row.has_exp && r !== row.exp_res) begin
      mismatches++;
      if (mismatches <= 10) $display("directed row expectation differs: %h vs %h",
                                     row.exp_res, r);
    end
    pending_results.push_back(r);
  endtask

  function automatic stim_row_t mk(logic cmd, logic [31:0] sx, logic [31:0] sy,
                                   logic [31:0] wt, logic [5:0] rx, logic [5:0] ry);
    stim_row_t s;
    s.cmd = cmd; s.sx = sx; s.sy = sy; s.wt = wt; s.rx = rx; s.ry = ry;
    s.has_exp = 0; s.exp_res = '0;
    return s;
  endfunction

  function automatic stim_row_t mk_exp(stim_row_t s, bin_result_t e);
    s.has_exp = 1;
    s.exp_res = e;
    return s;
  endfunction

  // random sample near the grid, or anywhere now and then
  function automatic logic [31:0] pick_sample(logic [31:0] f, logic [30:0] st, int n);
    longint v;
    if ($urandom_range(9) == 0) return $urandom;
    v = longint'($signed(f)) + (longint'($urandom_range(n + 1)) - 1) * longint'(st)
        + longint'($urandom_range(st));
    return v[31:0];
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    stim_row_t s;
    int nx, ny;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    nx = (sh_cells_x > MAXX) ? MAXX : int'(sh_cells_x);
    ny = (sh_cells_y > MAXY) ? MAXY : int'(sh_cells_y);
    for (int i = 0; i < count; i++) begin
      s = mk($urandom_range(4) == 0, pick_sample(sh_first_x, sh_step_x, nx),
             pick_sample(sh_first_y, sh_step_y, ny), $urandom,
             6'($urandom_range(nx)), 6'($urandom_range(ny)));
      if ($urandom_range(7) == 0) s.wt = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      if ($urandom_range(15) == 0) begin s.rx = 6'($urandom); s.ry = 6'($urandom); end
      push_beat(s);
    end
    in_tvalid <= 0;
  endtask

  task automatic set_grid(logic [1:0] m, logic [31:0] fx, logic [31:0] stx,
                          logic [31:0] fy, logic [31:0] sty, logic [6:0] nx,
                          logic [6:0] ny);
    write_reg(REG_MODE, {30'b0, m});
    write_reg(REG_FIRST_X, fx);
    write_reg(REG_STEP_X, stx);
    write_reg(REG_FIRST_Y, fy);
    write_reg(REG_STEP_Y, sty);
    write_reg(REG_CELLS_X, {25'b0, nx});
    write_reg(REG_CELLS_Y, {25'b0, ny});
  endtask

  initial begin
    stim_row_t dir_rows[$];
    bin_result_t e;
    int wait_cycles;
    rst_n = 0;
    in_tvalid = 0; in_tuser = 0; in_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    out_tready = 0;
    foreach (shadow_bins[i]) shadow_bins[i] = '0;
    sh_mode = MODE_1D_COUNT; sh_first_x = 0; sh_step_x = 65536;
    sh_first_y = 0; sh_step_y = 65536; sh_cells_x = 64; sh_cells_y = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed, reset settings: 1D count, unit steps from zero
    e = '0; e.ok = 1; e.cx = 3; e.value = 48'd65536;
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'h0003_8000, 0, 0, 0, 0), e));
    e.value = 48'd131072;
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'h0003_0000, 0, 0, 0, 0), e));
    e = '0;  // below first node: floor makes it -1, dropped
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'hffff_ffff, 0, 0, 0, 0), e));
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'h8000_0000, 0, 0, 0, 0), e));
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'h0040_0000, 0, 0, 0, 0), e));
    e.ok = 1; e.cx = 63; e.value = 48'd65536;
    dir_rows.push_back(mk_exp(mk(CMD_ADD, 32'h003f_ffff, 0, 0, 0, 0), e));
    e.cx = 3; e.value = 48'd131072;  // read returns then clears
    dir_rows.push_back(mk_exp(mk(CMD_READ, 0, 0, 0, 6'd3, 6'd63), e));
    e.value = 0;
    dir_rows.push_back(mk_exp(mk(CMD_READ, 0, 0, 0, 6'd3, 6'd0), e));
    dir_rows.push_back(mk(CMD_ADD, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 6'h3f, 6'h3f));
    dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 6'h3f, 6'h3f));
    foreach (dir_rows[i]) push_beat(dir_rows[i]);
    in_tvalid <= 0;
    settle();

    // weighted: large weights of both signs on two bins
    dir_rows.delete();
    write_reg(REG_MODE, {30'b0, MODE_1D_WEIGHTED});
    for (int i = 0; i < 4; i++) dir_rows.push_back(mk(CMD_ADD, 32'h0001_0000, 0, 32'h7fff_ffff, 0, 0));
    dir_rows.push_back(mk(CMD_READ, 0, 0, 0, 6'd1, 0));
    for (int i = 0; i < 3; i++) dir_rows.push_back(mk(CMD_ADD, 32'h0002_0000, 0, 32'h8000_0000, 0, 0));
    foreach (dir_rows[i]) push_beat(dir_rows[i]);
    in_tvalid <= 0;
    settle();
    // load one bin with large positive weights before the random weighted traffic
    begin
      stim_row_t s;
      s = mk(CMD_ADD, 32'h0005_0000, 0, 32'h7fff_ffff, 0, 0);
      for (int i = 0; i < 3; i++) push_beat(s);
      in_tvalid <= 0;
    end
    settle();

    // phases: fixed and random settings, every idling mix, extremes among them
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: set_grid(MODE_2D_COUNT, 32'hfff0_0000, 32'h0002_0000, 32'h0010_0000,
                    32'h0000_8000, 7'd8, 7'd8);
        1: set_grid(MODE_1D_WEIGHTED, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'd1, 7'd64, 7'd64);
        2: set_grid(2'd3 - ph[3], $urandom, $urandom_range(32'h7fff_ffff, 1),
                    $urandom, $urandom_range(32'h7fff_ffff, 1), 7'd127, 7'd100);
        default: set_grid(ph[2] ? MODE_2D_COUNT : MODE_1D_COUNT, 32'h7fff_ffff, 32'd1,
                          32'h8000_0000, ph[3] ? 32'd0 : 32'd3, ph[2] ? 7'd0 : 7'd1, 7'd1);
      endcase
      case (ph % 4)
        0: random_phase(140, 0, 0);
        1: random_phase(140, 72, 0);
        2: random_phase(140, 0, 72);
        default: random_phase(140, 25, 25);
      endcase
      settle();
    end
    random_phase(20, 0, 0);  // hold-off: wait for everything, then resume
    while (pending_results.size() != 0) @(posedge clk);
    random_phase(20, 0, 0);

    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
